[design/voltage_lut_interpolator_top_defines.svh]
// ----------------------------------------------------------------------------
// Voltage LUT interpolator assertion macros
// Concurrent check macros shared by the RTL; NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef VOLTAGE_LUT_INTERPOLATOR_TOP_DEFINES_SVH
`define VOLTAGE_LUT_INTERPOLATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset
`define VLI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voltage_lut_interpolator: check failed");
// Next-cycle implication, sampled on clk, off during reset
`define VLI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voltage_lut_interpolator: check failed");
`else
`define VLI_ASSERT_NOW(lbl, ante, cons)
`define VLI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/vli_pkg.sv]
// ----------------------------------------------------------------------------
// Voltage LUT interpolator package
// Widths, the measured compensation table and shared control types.
// ----------------------------------------------------------------------------
package vli_pkg;

    // Field widths (Q16 volts)
    localparam int VOLT_W   = 21;
    localparam int MAG_W    = 20;
    localparam int POS_W    = 24;
    localparam int FRAC_W   = 16;
    localparam int TVAL_W   = 20;
    localparam int TIDX_W   = 8;

    // Saturation limit, plus/minus 12 V
    localparam logic signed [VOLT_W-1:0] VOLT_MAX = 21'sd786432;

    // Default number of table positions
    localparam int TABLE_ENTRIES_DEF = 51;

    // Entries actually stored; positions past them read the last one
    localparam int STORED_ENTRIES = 51;
    localparam int STORED_IDX_W   = $clog2(STORED_ENTRIES);

    // Measured drive voltages in Q16, 0.1 V apart from 0 V
    localparam logic [TVAL_W-1:0] MEASURED_Q16 [STORED_ENTRIES] = '{
        20'd111,    20'd111,    20'd111,    20'd193,    20'd482,
        20'd931,    20'd2844,   20'd8756,   20'd18553,  20'd32883,
        20'd43670,  20'd54264,  20'd67895,  20'd77857,  20'd89457,
        20'd99877,  20'd109117, 20'd117768, 20'd129401, 20'd137691,
        20'd146080, 20'd156828, 20'd164725, 20'd172491, 20'd181600,
        20'd191365, 20'd198705, 20'd206111, 20'd215613, 20'd222691,
        20'd229638, 20'd238813, 20'd246088, 20'd252838, 20'd261816,
        20'd268567, 20'd275251, 20'd284099, 20'd290849, 20'd297599,
        20'd306315, 20'd313328, 20'd320012, 20'd328532, 20'd330498,
        20'd338297, 20'd347668, 20'd354419, 20'd361759, 20'd370344,
        20'd376963
    };

    // Table read with clamp to the last stored entry
    function automatic logic [TVAL_W-1:0] table_at(input logic [TIDX_W-1:0] i);
        logic [TIDX_W-1:0] c;
        c = (i >= TIDX_W'(STORED_ENTRIES - 1)) ? TIDX_W'(STORED_ENTRIES - 1) : i;
        return MEASURED_Q16[c[STORED_IDX_W-1:0]];
    endfunction

    // Pipeline control from the top level
    typedef struct packed {
        logic advance;
        logic mirror;
    } vli_ctrl_t;

endpackage

[design/vli_pipe.sv]
// ----------------------------------------------------------------------------
// Voltage LUT interpolator pipeline
// Five-stage datapath: saturate/fold, position, table read, multiply, output.
// ----------------------------------------------------------------------------
module vli_pipe #(
    parameter int TABLE_ENTRIES = vli_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vli_pkg::vli_ctrl_t                ctrl,
    input  logic                              in_valid,
    input  logic signed [vli_pkg::VOLT_W-1:0] in_volt,
    output logic                              out_valid,
    output logic signed [vli_pkg::VOLT_W-1:0] out_volt,
    output logic                              out_used
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [vli_pkg::POS_W-1:0] SPAN =
        vli_pkg::POS_W'((TABLE_ENTRIES - 1) * 65536);
    localparam logic signed [37:0] PROD_HALF = 38'sd32768;

    // Stage valid bits
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;

    // Stage payloads
    logic [vli_pkg::MAG_W-1:0]     s1_mag_reg, s2_mag_reg, s3_mag_reg, s4_mag_reg;
    logic                          s1_neg_reg, s2_neg_reg, s3_neg_reg, s4_neg_reg;
    logic                          s2_pass_reg, s3_pass_reg, s4_pass_reg;
    logic [IDX_W-1:0]              s2_idx_reg;
    logic [vli_pkg::FRAC_W-1:0]    s2_frac_reg, s3_frac_reg;
    logic signed [vli_pkg::VOLT_W-1:0] s3_m0_reg, s4_m0_reg;
    logic signed [vli_pkg::VOLT_W-1:0] s3_diff_reg;
    logic signed [21:0]            s4_step_reg;
    logic signed [vli_pkg::VOLT_W-1:0] s5_volt_reg;
    logic                          s5_used_reg;

    // Stage 1: saturate, fold negative commands to a magnitude
    logic signed [vli_pkg::VOLT_W-1:0] sat_v;
    logic signed [vli_pkg::VOLT_W-1:0] abs_v;
    logic                              s1_neg_next;
    logic [vli_pkg::MAG_W-1:0]         s1_mag_next;
    always_comb
    begin
        if (in_volt > vli_pkg::VOLT_MAX)
            sat_v = vli_pkg::VOLT_MAX;
        else if (in_volt < -vli_pkg::VOLT_MAX)
            sat_v = -vli_pkg::VOLT_MAX;
        else
            sat_v = in_volt;
        s1_neg_next = sat_v[vli_pkg::VOLT_W-1] & ctrl.mirror;
        // non-mirrored zero or negative reads table entry zero
        if (s1_neg_next)
            abs_v = -sat_v;
        else if (sat_v[vli_pkg::VOLT_W-1])
            abs_v = '0;
        else
            abs_v = sat_v;
        s1_mag_next = abs_v[vli_pkg::MAG_W-1:0];
    end

    // Stage 2: table position = 10 * magnitude
    logic [vli_pkg::POS_W-1:0] pos;
    assign pos = (vli_pkg::POS_W'(s1_mag_reg) << 3) + (vli_pkg::POS_W'(s1_mag_reg) << 1);

    // Stage 3: neighbor entries and their difference
    logic [vli_pkg::TIDX_W-1:0]        idx0, idx1;
    logic signed [vli_pkg::VOLT_W-1:0] m0, m1;
    always_comb
    begin
        idx0 = vli_pkg::TIDX_W'(s2_idx_reg);
        idx1 = idx0 + vli_pkg::TIDX_W'(1);
        m0   = $signed({1'b0, vli_pkg::table_at(idx0)});
        m1   = $signed({1'b0, vli_pkg::table_at(idx1)});
    end

    // Stage 4: rounded step, half toward plus infinity
    logic signed [16:0] frac_s;
    logic signed [37:0] prod;
    always_comb
    begin
        frac_s = $signed({1'b0, s3_frac_reg});
        prod   = s3_diff_reg * frac_s + PROD_HALF;
    end

    // Stage 5: add, restore sign, select pass-through
    logic signed [22:0]                sum, sum_s;
    logic signed [vli_pkg::VOLT_W-1:0] pass_v;
    always_comb
    begin
        sum    = 23'(s4_m0_reg) + 23'(s4_step_reg);
        sum_s  = s4_neg_reg ? -sum : sum;
        pass_v = s4_neg_reg ? -$signed({1'b0, s4_mag_reg}) : $signed({1'b0, s4_mag_reg});
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Payload registers, all held while stalled
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            s1_mag_reg  <= s1_mag_next;
            s1_neg_reg  <= s1_neg_next;

            s2_mag_reg  <= s1_mag_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_pass_reg <= (pos >= SPAN);
            s2_idx_reg  <= pos[vli_pkg::FRAC_W +: IDX_W];
            s2_frac_reg <= pos[vli_pkg::FRAC_W-1:0];

            s3_mag_reg  <= s2_mag_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_pass_reg <= s2_pass_reg;
            s3_frac_reg <= s2_frac_reg;
            s3_m0_reg   <= m0;
            s3_diff_reg <= m1 - m0;

            s4_mag_reg  <= s3_mag_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_pass_reg <= s3_pass_reg;
            s4_m0_reg   <= s3_m0_reg;
            s4_step_reg <= prod[37:16];

            s5_volt_reg <= s4_pass_reg ? pass_v : sum_s[vli_pkg::VOLT_W-1:0];
            s5_used_reg <= ~s4_pass_reg;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_volt  = s5_volt_reg;
    assign out_used  = s5_used_reg;

endmodule

[design/voltage_lut_interpolator_top.sv]
// ----------------------------------------------------------------------------
// Voltage LUT interpolator
// Compensated drive voltage by linear interpolation of a measured table.
// ----------------------------------------------------------------------------
//  channel     signals                                   direction
//  target      target_valid, target_stall, cmd_voltage   request in
//  corrected   corrected_valid, corrected_stall,
//              drive_voltage, table_used                 request out
//  config      cfg_write_en, cfg_write_data (mirror)      write only
//
//  One request per cycle while corrected_stall does not hold the pipeline;
//  each result passes through the five pipeline stages (fold, position,
//  table read, multiply, output register); the multiply sits alone in its stage.
//  Reset clears all valid bits and sets mirror mode on.
//  corrected_stall freezes every stage and raises target_stall in the
//  same cycle while a result is waiting.
// ----------------------------------------------------------------------------
`include "voltage_lut_interpolator_top_defines.svh"

module voltage_lut_interpolator_top #(
    parameter int TABLE_ENTRIES = vli_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic                              cfg_write_data,
    input  logic                              target_valid,
    output logic                              target_stall,
    input  logic signed [vli_pkg::VOLT_W-1:0] cmd_voltage,
    output logic                              corrected_valid,
    input  logic                              corrected_stall,
    output logic signed [vli_pkg::VOLT_W-1:0] drive_voltage,
    output logic                              table_used
);

    logic               mirror_reg;
    vli_pkg::vli_ctrl_t ctrl;

    // Mirror mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mirror_reg <= 1'b1;
        else if (cfg_write_en)
            mirror_reg <= cfg_write_data;
    end

    // Pipeline moves unless a finished result is held
    always_comb
    begin
        ctrl.advance = ~(corrected_valid & corrected_stall);
        ctrl.mirror  = mirror_reg;
    end
    assign target_stall = ~ctrl.advance;

    vli_pipe #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .in_valid (target_valid),
        .in_volt  (cmd_voltage),
        .out_valid(corrected_valid),
        .out_volt (drive_voltage),
        .out_used (table_used)
    );

    // Checks
    `VLI_ASSERT_NOW(a_stall_source, target_stall, corrected_valid && corrected_stall)
    `VLI_ASSERT_NOW(a_pass_nonzero, corrected_valid && !table_used, drive_voltage != 21'sd0)
    `VLI_ASSERT_NEXT(a_stall_freeze, corrected_valid && corrected_stall, corrected_valid && $stable(table_used))

endmodule

[bench/voltage_lut_interpolator_checker.sv]
// ----------------------------------------------------------------------------
// Voltage LUT interpolator checker
// Watches the target, corrected and config ports, predicts each compensated
// voltage from the measured table and compares it with what the block gives.
// ----------------------------------------------------------------------------
module voltage_lut_interpolator_checker
    import vli_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic                      cfg_write_data,
    input  logic                      target_valid,
    input  logic                      target_stall,
    input  logic signed [VOLT_W-1:0]  cmd_voltage,
    input  logic                      corrected_valid,
    input  logic                      corrected_stall,
    input  logic signed [VOLT_W-1:0]  drive_voltage,
    input  logic                      table_used,
    output int                        error_count,
    output int                        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [VOLT_W-1:0] voltage;
        logic                     used;
    } compensated_t;

    // Start of the pass-through region: (entries - 1) steps of 0.1 V
    localparam longint SPAN_POS = longint'(TABLE_ENTRIES - 1) * 65536;
    localparam longint SAT_LIMIT = 786432;

    compensated_t corrected_queue[$];
    logic         mirror_on   = 1'b1;
    int           mismatches  = 0;
    int           outstanding = 0;

    assign error_count   = mismatches;
    assign pending_count = outstanding;

    // Measured value at a table position, last stored entry past the end
    function automatic longint measured_at(input int pos_idx);
        int clamped;
        clamped = (pos_idx >= STORED_ENTRIES) ? STORED_ENTRIES - 1 : pos_idx;
        return longint'(MEASURED_Q16[clamped]);
    endfunction

    // Compensated voltage for one command under the current mirror mode
    function automatic compensated_t compensate(input logic signed [VOLT_W-1:0] cmd,
                                                input logic mirror);
        compensated_t result;
        longint       v;
        longint       mag;
        longint       pos;
        longint       frac;
        longint       m0;
        longint       m1;
        longint       prod;
        longint       value;
        logic         fold;
        int           seg;
        v = longint'(cmd);
        if (v > SAT_LIMIT)
            v = SAT_LIMIT;
        if (v < -SAT_LIMIT)
            v = -SAT_LIMIT;
        fold = (v < 0) && mirror;
        mag  = fold ? -v : v;
        pos  = mag * 10;
        if (pos >= SPAN_POS)
        begin
            result.used = 1'b0;
            value       = mag;
        end
        else
        begin
            result.used = 1'b1;
            if (mag <= 0)
                value = measured_at(0);
            else
            begin
                seg   = int'(pos >>> 16);
                frac  = pos & 64'hFFFF;
                m0    = measured_at(seg);
                m1    = measured_at(seg + 1);
                // round half up: floor of (delta * frac + 32768) / 65536
                prod  = (m1 - m0) * frac + 32768;
                value = m0 + (prod >>> 16);
            end
        end
        if (fold)
            value = -value;
        result.voltage = value[VOLT_W-1:0];
        return result;
    endfunction

    // Score results, queue predictions, track the mirror register
    always @(posedge clk or negedge rst_n)
    begin
        compensated_t expected;
        int           found;
        if (!rst_n)
        begin
            mirror_on = 1'b1;
            corrected_queue.delete();
            outstanding <= 0;
        end
        else
        begin
            found = 0;
            if (corrected_valid && !corrected_stall)
            begin
                if (corrected_queue.size() == 0)
                begin
                    $display("%0t: corrected request with none expected: voltage %0d used %0b",
                             $time, drive_voltage, table_used);
                    found++;
                end
                else
                begin
                    expected = corrected_queue.pop_front();
                    if (drive_voltage !== expected.voltage)
                    begin
                        $display("%0t: drive_voltage expected %0d actual %0d",
                                 $time, expected.voltage, drive_voltage);
                        found++;
                    end
                    if (table_used !== expected.used)
                    begin
                        $display("%0t: table_used expected %0b actual %0b",
                                 $time, expected.used, table_used);
                        found++;
                    end
                end
            end
            if (target_valid && !target_stall)
                corrected_queue.push_back(compensate(cmd_voltage, mirror_on));
            if (cfg_write_en)
                mirror_on = cfg_write_data;
            mismatches  <= mismatches + found;
            outstanding <= corrected_queue.size();
        end
    end

endmodule

[bench/voltage_lut_interpolator_top_test.sv]
// ----------------------------------------------------------------------------
// Voltage LUT interpolator testbench
// Drives target voltage requests (directed corners, then random mixes under
// both mirror settings and three idling profiles) and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module voltage_lut_interpolator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vli_pkg::*;

    localparam int     TABLE_ENTRIES    = TABLE_ENTRIES_DEF;
    localparam int     CLK_HALF         = 6;
    localparam int     RESET_CYCLES     = 11;
    localparam int     SETTLE_CYCLES    = 10;
    localparam int     LONG_HOLD_CYCLES = 60;
    localparam longint RUN_LIMIT_NS     = 2_000_000;

    // Corners with mirror at its reset value
    localparam int MIRROR_ON_CASES [18] = '{
        0, 1, -1, 111, 6553, 6554, 13107, 200000, 320000, 327679,
        327680, -327679, -327680, -200000, 786432, -786432, 1048575, -1048576
    };
    // Negative commands with mirror off
    localparam int MIRROR_OFF_CASES [6] = '{
        -1, -6554, -200000, -327679, -327680, -1048576
    };

    logic                     clk             = 1'b0;
    logic                     rst_n           = 1'b0;
    logic                     cfg_write_en    = 1'b0;
    logic                     cfg_write_data  = 1'b1;
    logic                     target_valid    = 1'b0;
    logic                     target_stall;
    logic signed [VOLT_W-1:0] cmd_voltage     = '0;
    logic                     corrected_valid;
    logic                     corrected_stall = 1'b0;
    logic signed [VOLT_W-1:0] drive_voltage;
    logic                     table_used;

    int   error_count;
    int   pending_count;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_start    = 1'b0;
    logic hold_active   = 1'b0;

    voltage_lut_interpolator_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .target_valid     (target_valid),
        .target_stall     (target_stall),
        .cmd_voltage      (cmd_voltage),
        .corrected_valid  (corrected_valid),
        .corrected_stall  (corrected_stall),
        .drive_voltage    (drive_voltage),
        .table_used       (table_used)
    );

    voltage_lut_interpolator_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .target_valid     (target_valid),
        .target_stall     (target_stall),
        .cmd_voltage      (cmd_voltage),
        .corrected_valid  (corrected_valid),
        .corrected_stall  (corrected_stall),
        .drive_voltage    (drive_voltage),
        .table_used       (table_used),
        .error_count      (error_count),
        .pending_count    (pending_count)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // Receiver back-pressure: random stalls, or the long hold when active
    always @(posedge clk)
    begin
        corrected_stall <= hold_active || (int'($urandom_range(99)) < recv_idle_pct);
    end

    // Long receiver hold so the pipeline fills and stalls the target side
    initial
    begin
        wait (hold_start);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("voltage_lut_interpolator_top verification failed");
        $finish;
    end

    // Random command: mostly inside the table span, some near segment
    // boundaries, some pass-through, some anywhere in the 21-bit field
    function automatic logic signed [VOLT_W-1:0] random_target();
        int pick;
        int mag;
        pick = int'($urandom_range(99));
        if (pick < 55)
            mag = int'($urandom_range(327679));
        else if (pick < 70)
            mag = (int'($urandom_range(50)) * 65536 + 5) / 10 + int'($urandom_range(6)) - 3;
        else if (pick < 85)
            mag = int'($urandom_range(786432, 327680));
        else
            return VOLT_W'($urandom());
        if ($urandom_range(1))
            mag = -mag;
        return VOLT_W'(mag);
    endfunction

    // One target request, with random idle cycles ahead of it
    task automatic send_target(input logic signed [VOLT_W-1:0] value);
        if (int'($urandom_range(99)) < send_idle_pct)
        begin
            target_valid <= 1'b0;
            @(posedge clk);
            while (int'($urandom_range(99)) < send_idle_pct)
                @(posedge clk);
        end
        target_valid <= 1'b1;
        cmd_voltage  <= value;
        @(posedge clk);
        while (target_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle();
        target_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mirror(input logic value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_target(random_target());
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed corners, mirror as left by reset
        send_idle_pct = 29;
        recv_idle_pct = 68;
        foreach (MIRROR_ON_CASES[i])
            send_target(VOLT_W'(MIRROR_ON_CASES[i]));
        settle();
        write_mirror(1'b0);
        foreach (MIRROR_OFF_CASES[i])
            send_target(VOLT_W'(MIRROR_OFF_CASES[i]));

        // random, sender mostly busy, receiver mostly stalled
        run_random(200);
        settle();

        // random, mirror on, idling swapped
        write_mirror(1'b1);
        send_idle_pct = 68;
        recv_idle_pct = 29;
        run_random(200);
        settle();

        // no idling; long receiver hold at the start
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_mirror(1'b0);
        hold_start = 1'b1;
        run_random(100);
        settle();
        write_mirror(1'b1);
        run_random(100);
        settle();

        if (error_count == 0)
            $display("voltage_lut_interpolator_top verification clean");
        else
            $display("voltage_lut_interpolator_top verification failed");
        $finish;
    end

endmodule
